// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared property forms for the checker modules
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// File: rtl/itrt_pkg.sv
// ---------------------------------------------------------------------------
// itrt_pkg
// types, character codes and helpers for the radix text converter
// ---------------------------------------------------------------------------
package itrt_pkg;

   typedef enum logic [1:0] {
      BASE_BIN = 2'd0,
      BASE_OCT = 2'd1,
      BASE_DEC = 2'd2,
      BASE_HEX = 2'd3
   } base_type;

   localparam logic [7:0] CHAR_MINUS      = 8'h2d;
   localparam logic [7:0] CHAR_ZERO       = 8'h30;
   localparam logic [7:0] CHAR_LOWER_B    = 8'h62;
   localparam logic [7:0] CHAR_LOWER_X    = 8'h78;
   localparam logic [7:0] CHAR_ALPHA_BASE = 8'h57;

   localparam logic [3:0] DEC_LIMIT   = 4'd9;
   localparam logic [3:0] DABBLE_MIN  = 4'd5;
   localparam logic [3:0] DABBLE_ADD  = 4'd3;

   typedef struct packed {
      logic     load;
      logic     dabble;
      logic     shift;
      base_type base;
   } dig_cmd_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] code;
      logic       last;
   } char_beat_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      if (d <= DEC_LIMIT) begin
         return CHAR_ZERO + {4'd0, d};
      end else begin
         return CHAR_ALPHA_BASE + {4'd0, d};
      end
   endfunction

endpackage

// File: rtl/itrt_digits.sv
// ---------------------------------------------------------------------------
// itrt_digits
// digit shift register: loads radix digits, runs shift-and-add-3 for
// decimal one bit per cycle, and shifts digits out from the top
// ---------------------------------------------------------------------------
module itrt_digits
   import itrt_pkg::*;
#(
   parameter int VALUE_BITS = 64
) (
   input  logic                  clock,
   input  logic [VALUE_BITS-1:0] magnitude,
   input  dig_cmd_type           cmd,
   output logic [3:0]            top_digit
);

   localparam int ND_OCT   = (VALUE_BITS + 2) / 3;
   localparam int ND_HEX   = (VALUE_BITS + 3) / 4;
   localparam int ND_DEC   = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int OFF_OCT  = VALUE_BITS - ND_OCT;
   localparam int OFF_HEX  = VALUE_BITS - ND_HEX;
   localparam int OFF_DEC  = VALUE_BITS - ND_DEC;
   localparam int PAD_BITS = VALUE_BITS + 3;

   logic [3:0]            dig_ff  [VALUE_BITS];
   logic [3:0]            dig_in  [VALUE_BITS];
   logic [3:0]            oct_dig [VALUE_BITS];
   logic [3:0]            hex_dig [VALUE_BITS];
   logic [3:0]            dab_adj [ND_DEC];
   logic [3:0]            dab_dig [ND_DEC];
   logic [VALUE_BITS-1:0] val_ff;
   logic [VALUE_BITS-1:0] val_in;
   logic [PAD_BITS-1:0]   pad;

   assign pad = {3'b000, magnitude};

   for (genvar i = 0; i < VALUE_BITS; i++) begin : g_load
      if (i >= OFF_OCT) begin : g_oct
         assign oct_dig[i] = {1'b0, pad[3*(i-OFF_OCT)+2 -: 3]};
      end else begin : g_oct_pad
         assign oct_dig[i] = 4'd0;
      end
      if (i >= OFF_HEX) begin : g_hex
         assign hex_dig[i] = pad[4*(i-OFF_HEX)+3 -: 4];
      end else begin : g_hex_pad
         assign hex_dig[i] = 4'd0;
      end
   end

   for (genvar k = 0; k < ND_DEC; k++) begin : g_dabble
      assign dab_adj[k] = (dig_ff[OFF_DEC+k] >= DABBLE_MIN) ?
                          dig_ff[OFF_DEC+k] + DABBLE_ADD : dig_ff[OFF_DEC+k];
      if (k == 0) begin : g_low
         assign dab_dig[k] = {dab_adj[k][2:0], val_ff[VALUE_BITS-1]};
      end else begin : g_up
         assign dab_dig[k] = {dab_adj[k][2:0], dab_adj[k-1][3]};
      end
   end

   always_comb begin
      val_in = val_ff;
      for (int i = 0; i < VALUE_BITS; i++) begin
         dig_in[i] = dig_ff[i];
      end
      priority if (cmd.load) begin
         val_in = magnitude;
         unique case (cmd.base)
            BASE_BIN: begin
               for (int i = 0; i < VALUE_BITS; i++) begin
                  dig_in[i] = {3'd0, magnitude[i]};
               end
            end
            BASE_OCT: begin
               for (int i = 0; i < VALUE_BITS; i++) begin
                  dig_in[i] = oct_dig[i];
               end
            end
            BASE_DEC: begin
               for (int i = 0; i < VALUE_BITS; i++) begin
                  dig_in[i] = 4'd0;
               end
            end
            BASE_HEX: begin
               for (int i = 0; i < VALUE_BITS; i++) begin
                  dig_in[i] = hex_dig[i];
               end
            end
            default: begin
               for (int i = 0; i < VALUE_BITS; i++) begin
                  dig_in[i] = 4'd0;
               end
            end
         endcase
      end else if (cmd.dabble) begin
         val_in = {val_ff[VALUE_BITS-2:0], 1'b0};
         for (int k = 0; k < ND_DEC; k++) begin
            dig_in[OFF_DEC+k] = dab_dig[k];
         end
      end else if (cmd.shift) begin
         dig_in[0] = 4'd0;
         for (int i = 1; i < VALUE_BITS; i++) begin
            dig_in[i] = dig_ff[i-1];
         end
      end else begin
         val_in = val_ff;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      for (int i = 0; i < VALUE_BITS; i++) begin
         dig_ff[i] <= dig_in[i];
      end
   end

   assign top_digit = dig_ff[VALUE_BITS-1];

endmodule

// File: rtl/itrt_pack.sv
// ---------------------------------------------------------------------------
// itrt_pack
// pairs the character stream into result beats with a registered output
// ---------------------------------------------------------------------------
module itrt_pack
   import itrt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  char_beat_type beat,
   output logic          rsp_valid,
   output logic [7:0]    rsp_char_first,
   output logic [7:0]    rsp_char_second,
   output logic          rsp_second_valid,
   output logic          rsp_last
);

   logic       pend_ff;
   logic       pend_in;
   logic [7:0] pend_char_ff;
   logic [7:0] pend_char_in;
   logic       valid_ff;
   logic       valid_in;
   logic [7:0] first_ff;
   logic [7:0] first_in;
   logic [7:0] second_ff;
   logic [7:0] second_in;
   logic       sec_valid_ff;
   logic       sec_valid_in;
   logic       last_ff;
   logic       last_in;

   always_comb begin
      pend_in      = pend_ff;
      pend_char_in = pend_char_ff;
      valid_in     = 1'b0;
      first_in     = first_ff;
      second_in    = second_ff;
      sec_valid_in = sec_valid_ff;
      last_in      = last_ff;
      if (beat.valid) begin
         priority if (pend_ff) begin
            valid_in     = 1'b1;
            first_in     = pend_char_ff;
            second_in    = beat.code;
            sec_valid_in = 1'b1;
            last_in      = beat.last;
            pend_in      = 1'b0;
         end else if (beat.last) begin
            valid_in     = 1'b1;
            first_in     = beat.code;
            second_in    = 8'd0;
            sec_valid_in = 1'b0;
            last_in      = 1'b1;
         end else begin
            pend_in      = 1'b1;
            pend_char_in = beat.code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
      pend_char_ff <= pend_char_in;
      first_ff     <= first_in;
      second_ff    <= second_in;
      sec_valid_ff <= sec_valid_in;
      last_ff      <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_char_first   = first_ff;
   assign rsp_char_second  = second_ff;
   assign rsp_second_valid = sec_valid_ff;
   assign rsp_last         = last_ff;

endmodule

// File: rtl/integer_to_radix_text_core.sv
// ---------------------------------------------------------------------------
// integer_to_radix_text_core
// Prints an unsigned magnitude with an optional minus sign as ASCII text in
// binary ("0b"), octal ("0"), decimal or lower-case hex ("0x"), most
// significant digit first with no leading zeros, up to two characters per
// result beat. A value is taken when start is high and busy low; busy then
// stays high through the sign, the prefix and every digit position, and for
// decimal through one-bit-per-cycle binary to BCD conversion before the
// digits. Digit positions are VALUE_BITS for binary, ceil(VALUE_BITS/3) for
// octal, ceil(VALUE_BITS/4) for hex and the decimal width of 2^VALUE_BITS-1
// for decimal; the digit shift register steps one position per cycle whether
// it skips a leading zero or prints. Each result beat shows on rsp_valid for
// a single cycle, in the cycle after its second or only character, and
// cannot be held off; the last one shows in the same cycle that busy falls.
// Magnitude bits at and above VALUE_BITS are ignored.
// ---------------------------------------------------------------------------
module integer_to_radix_text_core
   import itrt_pkg::*;
#(
   parameter int VALUE_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_magnitude,
   input  logic        req_is_negative,
   input  logic [1:0]  req_base_code,
   output logic        rsp_valid,
   output logic [7:0]  rsp_char_first,
   output logic [7:0]  rsp_char_second,
   output logic        rsp_second_valid,
   output logic        rsp_last
);

   localparam int REM_BITS = $clog2(VALUE_BITS + 1);
   localparam int DAB_BITS = $clog2(VALUE_BITS);
   localparam int ND_OCT   = (VALUE_BITS + 2) / 3;
   localparam int ND_HEX   = (VALUE_BITS + 3) / 4;
   localparam int ND_DEC   = (VALUE_BITS * 30103) / 100000 + 1;

   localparam logic [REM_BITS-1:0] REM_BIN  = REM_BITS'(VALUE_BITS);
   localparam logic [REM_BITS-1:0] REM_OCT  = REM_BITS'(ND_OCT);
   localparam logic [REM_BITS-1:0] REM_DEC  = REM_BITS'(ND_DEC);
   localparam logic [REM_BITS-1:0] REM_HEX  = REM_BITS'(ND_HEX);
   localparam logic [REM_BITS-1:0] REM_ONE  = REM_BITS'(1);
   localparam logic [DAB_BITS-1:0] DAB_LAST = DAB_BITS'(VALUE_BITS - 1);
   localparam logic [DAB_BITS-1:0] DAB_ZERO = '0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIGN,
      ST_PFX_ZERO,
      ST_PFX_LETTER,
      ST_DABBLE,
      ST_DIGIT
   } state_type;

   state_type           state_ff;
   state_type           state_in;
   base_type            base_ff;
   base_type            base_in;
   base_type            req_base;
   logic                lead_ff;
   logic                lead_in;
   logic [REM_BITS-1:0] rem_ff;
   logic [REM_BITS-1:0] rem_in;
   logic [DAB_BITS-1:0] dab_cnt_ff;
   logic [DAB_BITS-1:0] dab_cnt_in;
   dig_cmd_type         cmd;
   char_beat_type       beat;
   logic [3:0]          top_digit;

   assign req_base = base_type'(req_base_code);

   always_comb begin
      state_in   = state_ff;
      base_in    = base_ff;
      lead_in    = lead_ff;
      rem_in     = rem_ff;
      dab_cnt_in = dab_cnt_ff;
      cmd        = '0;
      cmd.base   = req_base;
      beat       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load   = 1'b1;
               base_in    = req_base;
               lead_in    = 1'b1;
               dab_cnt_in = DAB_LAST;
               unique case (req_base)
                  BASE_BIN: rem_in = REM_BIN;
                  BASE_OCT: rem_in = REM_OCT;
                  BASE_DEC: rem_in = REM_DEC;
                  BASE_HEX: rem_in = REM_HEX;
                  default:  rem_in = REM_BIN;
               endcase
               priority if (req_is_negative) begin
                  state_in = ST_SIGN;
               end else if (req_base == BASE_DEC) begin
                  state_in = ST_DABBLE;
               end else begin
                  state_in = ST_PFX_ZERO;
               end
            end
         end
         ST_SIGN: begin
            beat.valid = 1'b1;
            beat.code  = CHAR_MINUS;
            state_in   = (base_ff == BASE_DEC) ? ST_DABBLE : ST_PFX_ZERO;
         end
         ST_PFX_ZERO: begin
            beat.valid = 1'b1;
            beat.code  = CHAR_ZERO;
            state_in   = (base_ff == BASE_OCT) ? ST_DIGIT : ST_PFX_LETTER;
         end
         ST_PFX_LETTER: begin
            beat.valid = 1'b1;
            beat.code  = (base_ff == BASE_BIN) ? CHAR_LOWER_B : CHAR_LOWER_X;
            state_in   = ST_DIGIT;
         end
         ST_DABBLE: begin
            cmd.dabble = 1'b1;
            if (dab_cnt_ff == DAB_ZERO) begin
               state_in = ST_DIGIT;
            end else begin
               dab_cnt_in = dab_cnt_ff - 1'b1;
            end
         end
         ST_DIGIT: begin
            cmd.shift = 1'b1;
            rem_in    = rem_ff - 1'b1;
            if (!(lead_ff && top_digit == 4'd0 && rem_ff != REM_ONE)) begin
               beat.valid = 1'b1;
               beat.code  = digit_char(top_digit);
               beat.last  = (rem_ff == REM_ONE);
               lead_in    = 1'b0;
               if (rem_ff == REM_ONE) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      base_ff    <= base_in;
      lead_ff    <= lead_in;
      rem_ff     <= rem_in;
      dab_cnt_ff <= dab_cnt_in;
   end

   assign busy = (state_ff != ST_IDLE);

   itrt_digits #(
      .VALUE_BITS(VALUE_BITS)
   ) u_digits (
      .clock     (clock),
      .magnitude (req_magnitude[VALUE_BITS-1:0]),
      .cmd       (cmd),
      .top_digit (top_digit)
   );

   itrt_pack u_pack (
      .clock            (clock),
      .reset            (reset),
      .beat             (beat),
      .rsp_valid        (rsp_valid),
      .rsp_char_first   (rsp_char_first),
      .rsp_char_second  (rsp_char_second),
      .rsp_second_valid (rsp_second_valid),
      .rsp_last         (rsp_last)
   );

endmodule

// File: rtl/itrt_checker.sv
// ---------------------------------------------------------------------------
// itrt_checker
// port-level checks on the radix text converter, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module itrt_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [7:0] rsp_char_second,
   input logic       rsp_second_valid,
   input logic       rsp_last
);

   // a single-character beat only closes the text
   `ASSERT_IMPLY(a_odd_is_last, clock, reset, rsp_valid && !rsp_second_valid, rsp_last)

   `ASSERT_IMPLY(a_odd_second_zero, clock, reset, rsp_valid && !rsp_second_valid, rsp_char_second == 8'h00)

   `ASSERT_IMPLY(a_mid_beat_busy, clock, reset, rsp_valid && !rsp_last, busy)

   `ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)

   `ASSERT_NEXT(a_gap_after_last, clock, reset, rsp_valid && rsp_last, !rsp_valid)

endmodule

bind integer_to_radix_text_core itrt_checker u_checker (.*);
